@@ rtl/assert_macros.svh @@
// Assertion shorthands for the checkers. Each one is clocked on the rising edge
// and held off while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AST_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define AST_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/crc16b_pkg.sv @@
package crc16b_pkg;

    localparam int CRC_WIDTH  = 16;
    localparam int BYTE_WIDTH = 8;

    localparam logic [CRC_WIDTH-1:0] GENERATOR_RESET = 16'h4D4C;

    typedef struct packed {
        logic [BYTE_WIDTH-1:0] data_byte;
        logic                  last_byte;
    } in_item_t;

    typedef struct packed {
        logic [CRC_WIDTH-1:0] crc_value;
        logic                 crc_is_zero;
    } out_item_t;

endpackage

@@ rtl/crc16b_byte_update.sv @@
module crc16b_byte_update (
    input  logic [crc16b_pkg::CRC_WIDTH-1:0]  remainder,
    input  logic [crc16b_pkg::BYTE_WIDTH-1:0] data_byte,
    input  logic [crc16b_pkg::CRC_WIDTH-1:0]  generator,
    output logic [crc16b_pkg::CRC_WIDTH-1:0]  updated
);
    import crc16b_pkg::*;

    logic [CRC_WIDTH-1:0] r;

    // Fold the byte into the top of the remainder, then divide one bit at a time.
    always_comb
    begin
        r = remainder ^ {data_byte, {(CRC_WIDTH-BYTE_WIDTH){1'b0}}};
        for (int i = 0; i < BYTE_WIDTH; i++)
        begin
            if (r[CRC_WIDTH-1])
            begin
                r = {r[CRC_WIDTH-2:0], 1'b0} ^ generator;
            end
            else
            begin
                r = {r[CRC_WIDTH-2:0], 1'b0};
            end
        end
        updated = r;
    end

endmodule

@@ rtl/crc16_msb_first_byte.sv @@
// CRC-16 over message bytes, most significant bit first, configurable generator.
// Each result is built from the last byte in the input register, then registered.
// Throughput: one byte per cycle while no last byte waits on a held result; the
// byte-wide division fits between input register and remainder/result registers.
// Reset clears the remainder, the pipeline valids and sets the generator to 0x4D4C.
module crc16_msb_first_byte (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  crc16b_pkg::in_item_t                 item,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output crc16b_pkg::out_item_t                result,
    input  logic                                 cfg_write_en,
    input  logic [crc16b_pkg::CRC_WIDTH-1:0]     cfg_write_data
);
    import crc16b_pkg::*;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    in_item_t             s1_item_reg;
    logic [CRC_WIDTH-1:0] gen_reg;
    logic [CRC_WIDTH-1:0] gen_next;
    logic [CRC_WIDTH-1:0] rem_reg;
    logic [CRC_WIDTH-1:0] rem_next;
    logic                 res_valid_reg;
    logic                 res_valid_next;
    out_item_t            res_reg;

    logic                 out_free;
    logic                 s1_fire;
    logic                 accept;
    logic [CRC_WIDTH-1:0] updated;

    crc16b_byte_update u_update (
        .remainder (rem_reg),
        .data_byte (s1_item_reg.data_byte),
        .generator (gen_reg),
        .updated   (updated)
    );

    assign out_free   = !res_valid_reg || !result_stall;
    // A byte not marked last never waits on the output side.
    assign s1_fire    = s1_valid_reg && (!s1_item_reg.last_byte || out_free);
    assign item_stall = s1_valid_reg && !s1_fire;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end

        rem_next = rem_reg;
        if (s1_fire)
        begin
            rem_next = s1_item_reg.last_byte ? '0 : updated;
        end

        res_valid_next = res_valid_reg;
        if (s1_fire && s1_item_reg.last_byte)
        begin
            res_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_next = 1'b0;
        end

        gen_next = cfg_write_en ? cfg_write_data : gen_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rem_reg       <= '0;
            res_valid_reg <= 1'b0;
            gen_reg       <= GENERATOR_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rem_reg       <= rem_next;
            res_valid_reg <= res_valid_next;
            gen_reg       <= gen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item;
        end
        if (s1_fire && s1_item_reg.last_byte)
        begin
            res_reg.crc_value   <= updated;
            res_reg.crc_is_zero <= (updated == '0);
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

@@ rtl/crc16b_checker.sv @@
`include "assert_macros.svh"

module crc16b_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_stall,
    input  logic                  result_valid,
    input  logic                  result_stall,
    input  crc16b_pkg::out_item_t result
);
    import crc16b_pkg::*;

    // Input only backs up behind a result that is itself held.
    `AST_IMPLY(a_stall_cause, clk, rst_n, item_stall, result_valid && result_stall, "input stalled without a held result")

    // Zero flag must agree with the remainder it travels with.
    `AST_IMPLY(a_zero_flag, clk, rst_n, result_valid, result.crc_is_zero == (result.crc_value == '0), "zero flag disagrees with crc value")

    // Held result stays put.
    `AST_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")

    // Once the held result drains, input cannot still be blocked in that cycle.
    `AST_IMPLY(a_drain_unblocks, clk, rst_n, !result_stall, !item_stall, "input stalled while output drains")

endmodule

bind crc16_msb_first_byte crc16b_checker u_crc16b_checker (.*);
